[hdl/tset_pkg.sv]
// ----------------------------------------------------------------------------
// tset_pkg
// Shared types and constants of the time sorted entry table: field widths,
// request and status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tset_pkg;

  localparam int unsigned CAPACITY_DEF = 32;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned KEY_W  = HOUR_W + MIN_W;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 56;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_LIST
  } state_t;

  typedef struct packed {
    logic capture;
    logic apply;
    logic list_step;
  } cmd_t;

  typedef struct packed {
    logic req_is_list;
    logic table_empty;
    logic out_free;
    logic list_last;
  } stat_t;

endpackage

`default_nettype wire

[hdl/tset_ctrl.sv]
// ----------------------------------------------------------------------------
// tset_ctrl
// Request sequencer: takes one request, applies it to the cell chain once
// the result register is free, and steps through a listing.
// ----------------------------------------------------------------------------
`default_nettype none

module tset_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  input  tset_pkg::stat_t  stat,
  output tset_pkg::cmd_t   cmd
);

  tset_pkg::state_t state;
  tset_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tset_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tset_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = tset_pkg::ST_APPLY;
        end
      end
      tset_pkg::ST_APPLY: begin
        if (stat.req_is_list && !stat.table_empty) begin
          state_next = tset_pkg::ST_LIST;
        end else if (stat.out_free) begin
          state_next = tset_pkg::ST_IDLE;
        end
      end
      tset_pkg::ST_LIST: begin
        if (stat.out_free && stat.list_last) begin
          state_next = tset_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tset_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.apply     = 1'b0;
    cmd.list_step = 1'b0;
    unique case (state)
      tset_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      tset_pkg::ST_APPLY: begin
        cmd.apply = stat.out_free && !(stat.req_is_list && !stat.table_empty);
      end
      tset_pkg::ST_LIST: begin
        cmd.list_step = stat.out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/tset_datapath.sv]
// ----------------------------------------------------------------------------
// tset_datapath
// Chain of entry cells kept in time order, per-cell compare flags, position
// encoders and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tset_datapath #(
  parameter int unsigned CAPACITY = tset_pkg::CAPACITY_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  tset_pkg::cmd_t                   cmd,
  output tset_pkg::stat_t                  stat,
  input  wire  [tset_pkg::REQ_W-1:0]       in_req,
  input  tset_pkg::entry_t                 in_entry,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [tset_pkg::STAT_W-1:0]      out_status,
  output tset_pkg::entry_t                 out_entry,
  output logic [tset_pkg::POS_W-1:0]       out_pos,
  output logic                             out_last
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  tset_pkg::entry_t cells      [CAPACITY];
  tset_pkg::entry_t cells_next [CAPACITY];
  tset_pkg::entry_t prev_cell  [CAPACITY];
  tset_pkg::entry_t next_cell  [CAPACITY];

  logic [tset_pkg::REQ_W-1:0] req;
  tset_pkg::entry_t           req_entry;
  logic [CAPACITY-1:0]        le_flags;
  logic [CAPACITY-1:0]        match_flags;
  logic [CAPACITY-1:0]        le_comb;
  logic [CAPACITY-1:0]        match_comb;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  logic [CNT_W-1:0]           count_less;
  logic [CNT_W-1:0]           list_cnt;

  logic [CAPACITY-1:0] free_flags;
  logic [CAPACITY-1:0] ins_onehot;
  logic [CAPACITY-1:0] match_first;
  logic [CAPACITY-1:0] shift_up;
  logic [IDX_W-1:0]    ins_idx;
  logic [IDX_W-1:0]    match_idx;
  tset_pkg::entry_t    sel_entry;
  logic                full;
  logic                found;
  logic                do_insert;
  logic                do_remove;

  logic                          load;
  logic [tset_pkg::STAT_W-1:0]   status_next;
  tset_pkg::entry_t              entry_next;
  logic [tset_pkg::POS_W-1:0]    pos_next;
  logic                          last_next;

  assign count_less = count - 1'b1;
  assign full       = (count == CNT_W'(CAPACITY));
  assign found      = |match_flags;
  assign do_insert  = cmd.apply && (req == tset_pkg::REQ_INSERT) && !full;
  assign do_remove  = cmd.apply && (req == tset_pkg::REQ_REMOVE) && found;

  assign stat.req_is_list = (req == tset_pkg::REQ_LIST);
  assign stat.table_empty = (count == '0);
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.list_last   = (list_cnt == count_less);

  // per-cell flags against the incoming request
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le_comb[i]    = (CNT_W'(i) < count) &&
                      ({cells[i].hour, cells[i].minute} <=
                       {in_entry.hour, in_entry.minute});
      match_comb[i] = (CNT_W'(i) < count) && (cells[i].id == in_entry.id);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req         <= in_req;
      req_entry   <= in_entry;
      le_flags    <= le_comb;
      match_flags <= match_comb;
    end
  end

  // first free place and first match
  assign free_flags  = ~le_flags;
  assign ins_onehot  = free_flags & (~free_flags + 1'b1);
  assign match_first = match_flags & (~match_flags + 1'b1);
  assign shift_up    = ~(match_first - 1'b1);

  always_comb begin
    ins_idx   = '0;
    match_idx = '0;
    sel_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      ins_idx   = ins_idx   | (ins_onehot[i]  ? IDX_W'(i) : '0);
      match_idx = match_idx | (match_first[i] ? IDX_W'(i) : '0);
      sel_entry = sel_entry | (match_first[i] ? cells[i]  : '0);
    end
  end

  // neighbours in the chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
    if (g == 0) begin : g_first
      assign prev_cell[g] = '0;
    end else begin : g_prev
      assign prev_cell[g] = cells[g-1];
    end
    if (g == CAPACITY - 1) begin : g_lastc
      assign next_cell[g] = '0;
    end else begin : g_next
      assign next_cell[g] = cells[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (do_insert) begin
        if (ins_onehot[i]) begin
          cells_next[i] = req_entry;
        end else if (!le_flags[i]) begin
          cells_next[i] = prev_cell[i];
        end
      end else if (do_remove) begin
        if (shift_up[i]) begin
          cells_next[i] = next_cell[i];
        end
      end else if (cmd.list_step) begin
        if (CNT_W'(i) < count_less) begin
          cells_next[i] = next_cell[i];
        end else if (CNT_W'(i) == count_less) begin
          cells_next[i] = cells[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells[i] <= cells_next[i];
    end
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + 1'b1;
    end else if (do_remove) begin
      count_next = count_less;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      list_cnt <= '0;
    end else begin
      count <= count_next;
      if (cmd.capture) begin
        list_cnt <= '0;
      end else if (cmd.list_step) begin
        list_cnt <= list_cnt + 1'b1;
      end
    end
  end

  // result selection
  always_comb begin
    load        = cmd.apply || cmd.list_step;
    status_next = tset_pkg::STAT_OK;
    entry_next  = '0;
    pos_next    = '0;
    last_next   = 1'b1;
    if (cmd.list_step) begin
      entry_next = cells[0];
      pos_next   = tset_pkg::POS_W'(list_cnt);
      last_next  = stat.list_last;
    end else begin
      unique case (req)
        tset_pkg::REQ_INSERT: begin
          entry_next = req_entry;
          if (full) begin
            status_next = tset_pkg::STAT_FULL;
          end else begin
            pos_next = tset_pkg::POS_W'(ins_idx);
          end
        end
        tset_pkg::REQ_FIND, tset_pkg::REQ_REMOVE: begin
          if (found) begin
            entry_next = sel_entry;
            pos_next   = tset_pkg::POS_W'(match_idx);
          end else begin
            status_next   = tset_pkg::STAT_NOT_FOUND;
            entry_next.id = req_entry.id;
          end
        end
        tset_pkg::REQ_LIST: begin
          status_next = tset_pkg::STAT_EMPTY;
        end
        default: begin
          status_next = tset_pkg::STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= status_next;
      out_entry  <= entry_next;
      out_pos    <= pos_next;
      out_last   <= last_next;
    end
  end

endmodule

`default_nettype wire

[hdl/time_sorted_entry_table.sv]
// ----------------------------------------------------------------------------
// time_sorted_entry_table
// Table of up to CAPACITY entries held in time-of-day order, with insert,
// find, remove and list requests.
// ----------------------------------------------------------------------------
// Entries live in a chain of cells, one per place, so an insert or a remove
// moves every later entry by one place, all cells at once. A request is
// taken in the idle state, with all cells compared against it, and applied
// in the apply state once the result register is free. A list streams one
// entry per cycle while the result register is free, from the list state
// after the apply state, and a list of an empty table gives a single
// result. The table is empty after reset.
`default_nettype none

module time_sorted_entry_table #(
  parameter int unsigned CAPACITY = tset_pkg::CAPACITY_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // entry_id, time_hour, time_minute, payload_tag
  input  wire  [tset_pkg::S_TDATA_W-1:0]      s_tdata,
  // req_type
  input  wire  [tset_pkg::REQ_W-1:0]          s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // found_id, found_hour, found_minute, found_tag, position
  output logic [tset_pkg::M_TDATA_W-1:0]      m_tdata,
  // status
  output logic [tset_pkg::STAT_W-1:0]         m_tuser,
  output logic                                m_tlast
);

  localparam int unsigned PAD_W = tset_pkg::M_TDATA_W - $bits(tset_pkg::entry_t)
                                  - tset_pkg::POS_W;

  tset_pkg::cmd_t   cmd;
  tset_pkg::stat_t  stat;
  tset_pkg::entry_t in_entry;
  tset_pkg::entry_t out_entry;
  logic [tset_pkg::POS_W-1:0] out_pos;

  assign in_entry = s_tdata[$bits(tset_pkg::entry_t)-1:0];
  assign m_tdata  = {{PAD_W{1'b0}}, out_pos, out_entry};

  tset_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tset_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_req     (s_tuser),
    .in_entry   (in_entry),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_entry  (out_entry),
    .out_pos    (out_pos),
    .out_last   (m_tlast)
  );

endmodule

`default_nettype wire

[hdl/tset_checker.sv]
// ----------------------------------------------------------------------------
// tset_checker
// Port-level checks of the time sorted entry table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tset_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tvalid,
  input wire                          s_tready,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire                          m_tlast,
  input wire [tset_pkg::M_TDATA_W-1:0] m_tdata,
  input wire [tset_pkg::STAT_W-1:0]   m_tuser
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // no request taken in the middle of a listing
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("request taken during list");

  // failed requests give a single result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != tset_pkg::STAT_OK) |-> m_tlast)
    else $error("error result not final");

endmodule

bind time_sorted_entry_table tset_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[sim/time_sorted_entry_table_checker.sv]
// ----------------------------------------------------------------------------
// time_sorted_entry_table_checker
// Watches both stream channels of the time sorted entry table. Keeps its own
// copy of the table in time order, works out the results of each request
// transfer and compares every result transfer field by field with the
// oldest outstanding one.
// ----------------------------------------------------------------------------
`default_nettype none

module time_sorted_entry_table_checker
  import tset_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  s_tvalid,
  input  wire                  s_tready,
  input  wire [S_TDATA_W-1:0]  s_tdata,
  input  wire [REQ_W-1:0]      s_tuser,
  input  wire                  m_tvalid,
  input  wire                  m_tready,
  input  wire [M_TDATA_W-1:0]  m_tdata,
  input  wire [STAT_W-1:0]     m_tuser,
  input  wire                  m_tlast,
  output int                   fail_count,
  output int                   pending
);

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct {
    logic [STAT_W-1:0] status;
    entry_t            rec;
    logic [POS_W-1:0]  pos;
    logic              last;
  } table_result_t;

  entry_t        sorted_entries [CAPACITY];
  int            n_entries;
  table_result_t expected_results [$];

  initial begin
    fail_count = 0;
    pending    = 0;
    n_entries  = 0;
  end

  function automatic logic [KEY_W-1:0] time_key(entry_t e);
    return {e.hour, e.minute};
  endfunction

  task automatic push_result(logic [STAT_W-1:0] status, entry_t rec, int pos, logic last);
    table_result_t r;
    r.status = status;
    r.rec    = rec;
    r.pos    = POS_W'(pos);
    r.last   = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_request(logic [REQ_W-1:0] req, entry_t req_e);
    int     p;
    entry_t blank;
    blank = '0;
    case (req)
      REQ_INSERT: begin
        if (n_entries >= CAPACITY) begin
          push_result(STAT_FULL, req_e, 0, 1'b1);
        end else begin
          p = 0;
          while (p < n_entries && time_key(sorted_entries[p]) <= time_key(req_e)) p++;
          for (int i = n_entries; i > p; i--) sorted_entries[i] = sorted_entries[i-1];
          sorted_entries[p] = req_e;
          n_entries++;
          push_result(STAT_OK, req_e, p, 1'b1);
        end
      end
      REQ_FIND, REQ_REMOVE: begin
        p = 0;
        while (p < n_entries && sorted_entries[p].id != req_e.id) p++;
        if (p == n_entries) begin
          blank.id = req_e.id;
          push_result(STAT_NOT_FOUND, blank, 0, 1'b1);
        end else begin
          push_result(STAT_OK, sorted_entries[p], p, 1'b1);
          if (req == REQ_REMOVE) begin
            for (int i = p; i + 1 < n_entries; i++) sorted_entries[i] = sorted_entries[i+1];
            n_entries--;
            sorted_entries[n_entries] = '0;
          end
        end
      end
      default: begin
        if (n_entries == 0) begin
          push_result(STAT_EMPTY, blank, 0, 1'b1);
        end else begin
          for (int i = 0; i < n_entries; i++)
            push_result(STAT_OK, sorted_entries[i], i, i == n_entries - 1);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    table_result_t want;
    entry_t        got_e;
    if (rst) begin
      n_entries = 0;
      for (int i = 0; i < CAPACITY; i++) sorted_entries[i] = '0;
      expected_results.delete();
    end else begin
      // request first, so a result can never overtake its own expectation
      if (s_tvalid && s_tready)
        predict_request(s_tuser, entry_t'(s_tdata[ENTRY_W-1:0]));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result transfer tdata 0x%0h", m_tdata));
        end else begin
          want  = expected_results.pop_front();
          got_e = entry_t'(m_tdata[ENTRY_W-1:0]);
          check_field("status", 32'(m_tuser), 32'(want.status));
          check_field("found_id", 32'(got_e.id), 32'(want.rec.id));
          check_field("found_hour", 32'(got_e.hour), 32'(want.rec.hour));
          check_field("found_minute", 32'(got_e.minute), 32'(want.rec.minute));
          check_field("found_tag", 32'(got_e.tag), 32'(want.rec.tag));
          check_field("position", 32'(m_tdata[ENTRY_W +: POS_W]), 32'(want.pos));
          check_field("last_result", 32'(m_tlast), 32'(want.last));
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

`default_nettype wire

[sim/time_sorted_entry_table_tb.sv]
// ----------------------------------------------------------------------------
// time_sorted_entry_table_tb
// Regression for the time sorted entry table. A directed run covers the empty
// and full table, equal times, duplicate ids, missing ids and out of range
// times; random requests then alternate between filling and draining phases
// under changing idle patterns and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module time_sorted_entry_table_tb;
  import tset_pkg::*;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  wire                   s_tready;
  logic [S_TDATA_W-1:0]  s_tdata  = '0;
  logic [REQ_W-1:0]      s_tuser  = REQ_INSERT;
  wire                   m_tvalid;
  logic                  m_tready = 1'b0;
  wire  [M_TDATA_W-1:0]  m_tdata;
  wire  [STAT_W-1:0]     m_tuser;
  wire                   m_tlast;

  int fail_count;
  int pending;
  int snd_idle   = 24;
  int rcv_idle   = 45;
  int hold_token = 0;

  time_sorted_entry_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  time_sorted_entry_table_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random back-pressure, plus a long hold-off on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  task automatic send_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                              logic [HOUR_W-1:0] hour, logic [MIN_W-1:0] minute,
                              logic [TAG_W-1:0] tag);
    entry_t e;
    while ($urandom_range(99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    e.id     = id;
    e.hour   = hour;
    e.minute = minute;
    e.tag    = tag;
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= S_TDATA_W'(e);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    return ($urandom_range(99) < 85) ? ID_W'($urandom_range(15)) : ID_W'($urandom_range(65535));
  endfunction

  function automatic logic [HOUR_W-1:0] rand_hour();
    int r;
    r = $urandom_range(99);
    if (r < 40) return HOUR_W'($urandom_range(2));
    if (r < 90) return HOUR_W'($urandom_range(23));
    return HOUR_W'($urandom_range(31));
  endfunction

  function automatic logic [MIN_W-1:0] rand_minute();
    int r;
    r = $urandom_range(99);
    if (r < 40) return MIN_W'($urandom_range(1));
    if (r < 90) return MIN_W'($urandom_range(59));
    return MIN_W'($urandom_range(63));
  endfunction

  task automatic send_random(int k);
    int r;
    bit filling;
    r       = $urandom_range(99);
    filling = ((k / 50) % 2) == 0;
    if (r < 7)
      send_request(REQ_LIST, rand_id(), rand_hour(), rand_minute(), TAG_W'($urandom));
    else if (r < (filling ? 75 : 30))
      send_request(REQ_INSERT, rand_id(), rand_hour(), rand_minute(), TAG_W'($urandom));
    else if (r < (filling ? 87 : 50))
      send_request(REQ_FIND, rand_id(), rand_hour(), rand_minute(), TAG_W'($urandom));
    else
      send_request(REQ_REMOVE, rand_id(), rand_hour(), rand_minute(), TAG_W'($urandom));
  endtask

  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table
    send_request(REQ_LIST, 16'h0000, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_FIND, 16'hffff, 5'd31, 6'd63, 16'hffff);
    send_request(REQ_REMOVE, 16'h1234, 5'd0, 6'd0, 16'h0000);
    // extremes, equal times and out of range times
    send_request(REQ_INSERT, 16'h0000, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_INSERT, 16'hffff, 5'd23, 6'd59, 16'hffff);
    send_request(REQ_INSERT, 16'h0001, 5'd0, 6'd0, 16'h5555);
    send_request(REQ_INSERT, 16'haaaa, 5'd31, 6'd63, 16'haaaa);
    send_request(REQ_INSERT, 16'h0002, 5'd23, 6'd0, 16'h00ff);
    send_request(REQ_INSERT, 16'h0000, 5'd12, 6'd30, 16'hbeef);
    send_request(REQ_LIST, 16'h0000, 5'd0, 6'd0, 16'h0000);
    // duplicate id: the earlier time wins
    send_request(REQ_FIND, 16'h0000, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_FIND, 16'hffff, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_REMOVE, 16'h0000, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_FIND, 16'h0000, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_REMOVE, 16'h4321, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_REMOVE, 16'haaaa, 5'd0, 6'd0, 16'h0000);
    send_request(REQ_LIST, 16'h0000, 5'd0, 6'd0, 16'h0000);
    // fill up and overflow
    for (int i = 0; i < CAPACITY_DEF; i++)
      send_request(REQ_INSERT, rand_id(), rand_hour(), rand_minute(), TAG_W'($urandom));
    send_request(REQ_LIST, 16'h0000, 5'd0, 6'd0, 16'h0000);
    // drain with random removes of ids 0 to 15
    for (int i = 0; i < 60; i++)
      send_request(REQ_REMOVE, ID_W'($urandom_range(15)), 5'd0, 6'd0, 16'h0000);

    for (int k = 0; k < 290; k++) begin
      if (k == 90) begin
        snd_idle = 45;
        rcv_idle = 24;
      end
      if (k == 140) hold_token <= hold_token + 1;
      if (k == 180) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      send_random(k);
    end
    s_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("time_sorted_entry_table regression: pass");
    else
      $display("time_sorted_entry_table regression: fail");
    $finish;
  end

  initial begin
    #600000;
    $display("time_sorted_entry_table regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
